>>> rtl/sfr_pkg.sv
package sfr_pkg;

   // Longest pattern the match window supports
   localparam int MAX_PATTERN = 8;
   // Longest replacement
   localparam int MAX_REPLACE = 8;
   // Entries in the action queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register map, one register every 8 bytes
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } reg_index_type;

   // Input beat
   typedef struct packed {
      logic [7:0] char_in;
      logic       last_in;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic       last_out;
      logic       replaced_any;
   } rsp_type;

   // Configuration as seen by the datapath (lengths already clamped)
   typedef struct packed {
      logic [63:0] pattern;
      logic [3:0]  pattern_len;
      logic [63:0] replacement;
      logic [3:0]  replacement_len;
      logic        window_clear;
   } cfg_type;

   // One classified input byte: a run of bytes to send, plus end-of-string info
   typedef struct packed {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        last;
      logic        replaced;
   } action_type;

   // Clamp a 4-bit length field to a maximum
   function automatic logic [3:0] clamp_len(input logic [3:0] len, input logic [3:0] max_len);
      clamp_len = (len > max_len) ? max_len : len;
   endfunction

endpackage

>>> rtl/sfr_csr.sv
module sfr_csr import sfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [63:0] pattern_ff, pattern_in;
   logic [3:0]  pat_len_ff, pat_len_in;
   logic [63:0] repl_ff, repl_in;
   logic [3:0]  repl_len_ff, repl_len_in;
   logic        window_clear;

   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign wr_en  = psel && penable && pwrite;

   // Register writes; a pattern write also empties the match window at the same edge
   always_comb begin
      pattern_in   = pattern_ff;
      pat_len_in   = pat_len_ff;
      repl_in      = repl_ff;
      repl_len_in  = repl_len_ff;
      window_clear = 1'b0;
      if (wr_en) begin
         unique case (idx)
            REG_PATTERN_BYTES: begin
               pattern_in   = pwdata;
               window_clear = 1'b1;
            end
            REG_PATTERN_LENGTH: begin
               pat_len_in   = pwdata[3:0];
               window_clear = 1'b1;
            end
            REG_REPLACEMENT_BYTES: begin
               repl_in = pwdata;
            end
            REG_REPLACEMENT_LENGTH: begin
               repl_len_in = pwdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         pat_len_ff  <= '0;
         repl_ff     <= '0;
         repl_len_ff <= '0;
      end else begin
         pattern_ff  <= pattern_in;
         pat_len_ff  <= pat_len_in;
         repl_ff     <= repl_in;
         repl_len_ff <= repl_len_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         REG_PATTERN_BYTES:      prdata = pattern_ff;
         REG_PATTERN_LENGTH:     prdata = {60'd0, pat_len_ff};
         REG_REPLACEMENT_BYTES:  prdata = repl_ff;
         REG_REPLACEMENT_LENGTH: prdata = {60'd0, repl_len_ff};
         default:                prdata = '0;
      endcase
   end

   assign cfg.pattern         = pattern_ff;
   assign cfg.pattern_len     = clamp_len(pat_len_ff, 4'(MAX_PATTERN));
   assign cfg.replacement     = repl_ff;
   assign cfg.replacement_len = clamp_len(repl_len_ff, 4'(MAX_REPLACE));
   assign cfg.window_clear    = window_clear;

endmodule

>>> rtl/sfr_front.sv
module sfr_front import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   input  req_type    req_data,
   input  logic       queue_full,
   output logic       req_take,
   output logic       push,
   output action_type push_data
);

   // Match window: held bytes form a proper prefix of the pattern
   logic [7:0] win_ff [MAX_PATTERN];
   logic [7:0] win_in [MAX_PATTERN];
   logic [2:0] fill_ff, fill_in;
   logic       seen_ff, seen_in;

   logic [7:0] w [MAX_PATTERN];
   logic [3:0] f;
   logic       pfx [MAX_PATTERN];
   logic [3:0] start;
   logic       match;
   logic [3:0] rem;
   logic [63:0] w_flat;
   action_type act;

   assign req_take = req_valid && !queue_full;
   assign f        = {1'b0, fill_ff} + 4'd1;

   // Window with the new byte appended
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         w[i] = (3'(i) == fill_ff) ? req_data.char_in : win_ff[i];
         w_flat[8*i +: 8] = w[i];
      end
   end

   // For each start position: does the tail of the window begin the pattern
   always_comb begin
      for (int s = 0; s < MAX_PATTERN; s++) begin
         if (4'(s) >= f) begin
            pfx[s] = 1'b1;
         end else begin
            pfx[s] = ((f - 4'(s)) <= cfg.pattern_len);
            for (int k = 0; k < MAX_PATTERN; k++) begin
               if ((s + k < MAX_PATTERN) && (4'(s + k) < f) &&
                   (w[(s + k) % MAX_PATTERN] != cfg.pattern[8*k +: 8])) begin
                  pfx[s] = 1'b0;
               end
            end
         end
      end
   end

   // Leftmost start that can still grow into a match
   always_comb begin
      start = 4'(MAX_PATTERN);
      for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
         if (pfx[s]) begin
            start = 4'(s);
         end
      end
   end

   assign rem   = f - start;
   assign match = (start < f) && (rem == cfg.pattern_len);

   // Classify the byte and work out the next window
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_in[i] = win_ff[i];
      end
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      act.bytes    = w_flat;
      act.count    = 4'd0;
      act.last     = req_data.last_in;
      act.replaced = seen_ff;

      if (cfg.pattern_len == 4'd0) begin
         act.bytes = {56'd0, req_data.char_in};
         act.count = 4'd1;
         fill_in   = 3'd0;
      end else if (match) begin
         act.bytes    = cfg.replacement;
         act.count    = cfg.replacement_len;
         act.replaced = 1'b1;
         fill_in      = 3'd0;
         seen_in      = 1'b1;
      end else if (req_data.last_in) begin
         act.count = f;
         fill_in   = 3'd0;
      end else begin
         act.count = start;
         fill_in   = rem[2:0];
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (4'(i) + start < 4'(MAX_PATTERN)) begin
               win_in[i] = w[3'(4'(i) + start)];
            end
         end
      end

      if (req_data.last_in) begin
         seen_in = 1'b0;
      end
   end

   assign push      = req_take && ((act.count != 4'd0) || req_data.last_in);
   assign push_data = act;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         seen_ff <= 1'b0;
      end else if (cfg.window_clear) begin
         fill_ff <= '0;
      end else if (req_take) begin
         fill_ff <= fill_in;
         seen_ff <= seen_in;
      end
   end

   // Window bytes carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

>>> rtl/sfr_queue.sv
module sfr_queue import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  action_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output action_type head
);

   action_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         cnt_ff, cnt_in;
   logic                    do_pop;

   assign full       = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/sfr_back.sv
module sfr_back import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  action_type head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   rsp_type    out_ff, out_in;
   logic       out_valid_ff;
   logic [2:0] idx_ff, idx_in;
   logic       load;
   logic       bare;
   logic [2:0] final_idx;
   logic       is_final;

   // Output register takes a new beat when empty or draining
   assign load      = head_valid && (!out_valid_ff || !rsp_stall);
   assign bare      = (head.count == 4'd0);
   assign final_idx = bare ? 3'd0 : 3'(head.count - 4'd1);
   assign is_final  = (idx_ff == final_idx);
   assign pop       = load && is_final;

   // Build one result beat from the head action
   always_comb begin
      out_in.char_out     = bare ? 8'd0 : head.bytes[8*idx_ff +: 8];
      out_in.char_valid   = !bare;
      out_in.last_out     = head.last && is_final;
      out_in.replaced_any = head.last && is_final && head.replaced;
      idx_in              = idx_ff;
      if (load) begin
         idx_in = is_final ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/stream_find_replace.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_type (char_in, last_in)
// rsp       out        rsp_valid/rsp_stall  rsp_type (char_out, char_valid, last_out, replaced_any)
// csr       in         psel/penable/pready  64-bit registers at byte address 8*index
//
// One input byte is classified per cycle against the match window while the queue is not full;
// the back sends one result beat per cycle unless rsp_stall is high, one beat for each result.
// A four-entry action queue lets the front keep taking bytes while the back works off a burst.
// Reset is synchronous; the window contents are not reset, only its fill count.
// req_stall rises only when the action queue is full.
module stream_find_replace import sfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   logic       queue_full;
   logic       req_take;
   logic       push;
   action_type push_data;
   logic       pop;
   logic       head_valid;
   action_type head;

   assign req_stall = queue_full;

   sfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_take   (req_take),
      .push       (push),
      .push_data  (push_data)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
